// ===== hdl/vdr_pkg.sv =====
// ----------------------------------------------------------------------------
// vdr_pkg: shared types and constants of the duty regulator
// Field widths, register indexes, reset values, zone codes and the
// sequencer state type.
// ----------------------------------------------------------------------------
package vdr_pkg;

    localparam int SAMPLE_W = 12;
    localparam int DUTY_W   = 16;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FULL_DUTY      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_DUTY      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR_DUTY     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_THRESHOLD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIDDLE_UPPER   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_THRESHOLD  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RIPPLE_LIMIT   = 3'd6;

    // register reset values
    localparam logic [DUTY_W-1:0]   RST_FULL_DUTY      = 16'd6000;
    localparam logic [DUTY_W-1:0]   RST_HALF_DUTY      = 16'd3000;
    localparam logic [DUTY_W-1:0]   RST_FLOOR_DUTY     = 16'd1800;
    localparam logic [SAMPLE_W-1:0] RST_HIGH_THRESHOLD = 12'd1675;
    localparam logic [SAMPLE_W-1:0] RST_MIDDLE_UPPER   = 12'd1645;
    localparam logic [SAMPLE_W-1:0] RST_LOW_THRESHOLD  = 12'd1475;
    localparam logic [SAMPLE_W-1:0] RST_RIPPLE_LIMIT   = 12'd80;

    // zone codes
    localparam logic [1:0] ZONE_HIGH   = 2'd0;
    localparam logic [1:0] ZONE_MIDDLE = 2'd1;
    localparam logic [1:0] ZONE_LOW    = 2'd2;
    localparam logic [1:0] ZONE_NONE   = 2'd3;

    localparam logic [2:0] DERATE_MAX = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_DIV,
        ST_SCAN,
        ST_DONE
    } vdr_state_t;

endpackage

// ===== hdl/vdr_if.sv =====
// ----------------------------------------------------------------------------
// vdr_in_if / vdr_out_if: valid/ready channels of the duty regulator
// One word per handshake; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface vdr_in_if;
    import vdr_pkg::*;
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;
    logic                derate_tick;
    logic                raise_tick;

    modport source (output valid, output sample, output derate_tick,
                    output raise_tick, input ready);
    modport sink   (input valid, input sample, input derate_tick,
                    input raise_tick, output ready);
endinterface

interface vdr_out_if;
    import vdr_pkg::*;
    logic                valid;
    logic                ready;
    logic [DUTY_W-1:0]   duty;
    logic [SAMPLE_W-1:0] smoothed_level;
    logic                unstable;
    logic [1:0]          zone;

    modport source (output valid, output duty, output smoothed_level,
                    output unstable, output zone, input ready);
    modport sink   (input valid, input duty, input smoothed_level,
                    input unstable, input zone, output ready);
endinterface

// ===== hdl/voltage_derating_duty_regulator.sv =====
// ----------------------------------------------------------------------------
// voltage_derating_duty_regulator: supply-voltage duty derating controller
//
// Input channel in_ch carries one word per supply sample plus derate and
// raise tick flags; ticks latch until a zone consumes them. Output channel
// out_ch returns one word per input word: duty compare value, smoothed
// level, instability flag and zone code. The user writes registers through
// cfg_we / cfg_index / cfg_data while idle; the block itself never checks.
//
// One word is in flight at a time. An accepted word passes the slot ring,
// the mean by reciprocal multiply, the window ring and the zone decision
// before its result is registered. in_ch.ready is high only while idle,
// which begins as the result is registered, so the next word is accepted
// only once the previous one is through. A finished result waits in the
// output register while the receiver stalls; the next word is still
// accepted and computed, and its result is held until the register frees.
// Reset clears the sequencer, pointers, pending ticks, duty (full duty) and
// the registers; the first word after reset fills every slot and window cell
// with its sample, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module voltage_derating_duty_regulator
    import vdr_pkg::*;
#(
    parameter int SMOOTH_DEPTH = 32,
    parameter int WINDOW_DEPTH = 270
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    vdr_in_if.sink               in_ch,
    vdr_out_if.source            out_ch,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int SUM_W = SAMPLE_W + $clog2(SMOOTH_DEPTH);
    localparam int MAX_D = (SMOOTH_DEPTH > WINDOW_DEPTH) ? SMOOTH_DEPTH : WINDOW_DEPTH;
    localparam int CNT_W = $clog2(MAX_D + 2);

    // configuration registers
    logic [DUTY_W-1:0]   full_reg, half_reg, floor_reg;
    logic [SAMPLE_W-1:0] hi_th_reg, mid_up_reg, lo_th_reg, ripple_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg   <= RST_FULL_DUTY;
            half_reg   <= RST_HALF_DUTY;
            floor_reg  <= RST_FLOOR_DUTY;
            hi_th_reg  <= RST_HIGH_THRESHOLD;
            mid_up_reg <= RST_MIDDLE_UPPER;
            lo_th_reg  <= RST_LOW_THRESHOLD;
            ripple_reg <= RST_RIPPLE_LIMIT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FULL_DUTY:      full_reg   <= cfg_data;
                REG_HALF_DUTY:      half_reg   <= cfg_data;
                REG_FLOOR_DUTY:     floor_reg  <= cfg_data;
                REG_HIGH_THRESHOLD: hi_th_reg  <= cfg_data[SAMPLE_W-1:0];
                REG_MIDDLE_UPPER:   mid_up_reg <= cfg_data[SAMPLE_W-1:0];
                REG_LOW_THRESHOLD:  lo_th_reg  <= cfg_data[SAMPLE_W-1:0];
                REG_RIPPLE_LIMIT:   ripple_reg <= cfg_data[SAMPLE_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer
    vdr_state_t          state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg;
    logic                primed_reg;
    logic                fill_item_reg;
    logic [SAMPLE_W-1:0] samp_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [SAMPLE_W-1:0] mean_reg, mx_reg, mn_reg;
    logic                out_v_reg;
    logic                accept;
    logic                sum_last, scan_last, div_done, out_free;
    logic [SAMPLE_W-1:0] quotient;

    assign accept    = in_ch.valid && in_ch.ready;
    assign sum_last  = (cnt_reg == CNT_W'(SMOOTH_DEPTH));
    assign scan_last = (cnt_reg == CNT_W'(WINDOW_DEPTH));
    assign out_free  = !out_v_reg || out_ch.ready;
    assign in_ch.ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept)    state_next = ST_SUM;
            ST_SUM:  if (sum_last)  state_next = ST_DIV;
            ST_DIV:  if (div_done)  state_next = ST_SCAN;
            ST_SCAN: if (scan_last) state_next = ST_DONE;
            ST_DONE: if (out_free)  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // slot ring: head cell 0 leaves into the tail each rotation; the first
    // rotation writes the averaged slot, one extra rotation advances the head
    logic [SAMPLE_W-1:0] slot_val [SMOOTH_DEPTH];
    logic [SAMPLE_W-1:0] slot_tail;
    logic [SAMPLE_W:0]   slot_avg;
    logic                slot_shift;

    assign slot_avg   = {1'b0, slot_val[0]} + {1'b0, samp_reg};
    assign slot_tail  = (cnt_reg == '0 && !fill_item_reg) ? slot_avg[SAMPLE_W:1]
                                                          : slot_val[0];
    assign slot_shift = (state_reg == ST_SUM);

    for (genvar k = 0; k < SMOOTH_DEPTH; k++)
    begin : g_slot
        logic [SAMPLE_W-1:0] nb;
        if (k == SMOOTH_DEPTH - 1)
        begin : g_tail
            assign nb = slot_tail;
        end
        else
        begin : g_mid
            assign nb = slot_val[k+1];
        end
        vdr_cell #(.WIDTH(SAMPLE_W)) u_cell (
            .clk        (clk),
            .fill       (accept && !primed_reg),
            .fill_value (in_ch.sample),
            .shift      (slot_shift),
            .shift_in   (nb),
            .value      (slot_val[k])
        );
    end

    // window ring: the first rotation drops the oldest entry for the mean
    logic [SAMPLE_W-1:0] win_val [WINDOW_DEPTH];
    logic [SAMPLE_W-1:0] win_tail;
    logic                win_shift;

    assign win_tail  = (cnt_reg == '0) ? mean_reg : win_val[0];
    assign win_shift = (state_reg == ST_SCAN);

    for (genvar k = 0; k < WINDOW_DEPTH; k++)
    begin : g_win
        logic [SAMPLE_W-1:0] nb;
        if (k == WINDOW_DEPTH - 1)
        begin : g_tail
            assign nb = win_tail;
        end
        else
        begin : g_mid
            assign nb = win_val[k+1];
        end
        vdr_cell #(.WIDTH(SAMPLE_W)) u_cell (
            .clk        (clk),
            .fill       (accept && !primed_reg),
            .fill_value (in_ch.sample),
            .shift      (win_shift),
            .shift_in   (nb),
            .value      (win_val[k])
        );
    end

    vdr_div #(.DIVISOR(SMOOTH_DEPTH), .DIVIDEND_W(SUM_W)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == ST_SUM && sum_last),
        .dividend (sum_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            primed_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg != state_next)
            begin
                cnt_reg <= '0;
            end
            else if (state_reg == ST_SUM || state_reg == ST_SCAN)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (accept)
            begin
                primed_reg <= 1'b1;
            end
        end
    end

    // datapath: accumulate the sum, then the window extremes
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            samp_reg      <= in_ch.sample;
            fill_item_reg <= !primed_reg;
            sum_reg       <= '0;
        end
        if (state_reg == ST_SUM && !sum_last)
        begin
            sum_reg <= sum_reg + SUM_W'(slot_tail);
        end
        if (div_done)
        begin
            mean_reg <= quotient;
            mx_reg   <= '0;
            mn_reg   <= '1;
        end
        if (state_reg == ST_SCAN && !scan_last)
        begin
            if (win_tail > mx_reg) mx_reg <= win_tail;
            if (win_tail < mn_reg) mn_reg <= win_tail;
        end
    end

    // zone decision
    logic [DUTY_W-1:0] tgt_reg, tgt_next;
    logic [2:0]        dc_reg, dc_next;
    logic              low_reg, low_next;
    logic              pder_reg, pder_next;
    logic              prai_reg, prai_next;
    logic [1:0]        zone_next;
    logic              unstable;
    logic [DUTY_W-1:0] drop2, tgt_dec;
    logic              finish;

    assign unstable = (mx_reg - mn_reg) > ripple_reg;
    assign drop2    = (tgt_reg >= DUTY_W'(2)) ? tgt_reg - DUTY_W'(2) : '0;
    assign tgt_dec  = (tgt_reg > half_reg) ? tgt_reg - 1'b1 : tgt_reg;
    assign finish   = (state_reg == ST_DONE) && out_free;

    always_comb
    begin
        tgt_next  = tgt_reg;
        dc_next   = dc_reg;
        low_next  = low_reg;
        pder_next = pder_reg;
        prai_next = prai_reg;
        zone_next = ZONE_NONE;
        if (mean_reg >= hi_th_reg)
        begin
            zone_next = ZONE_HIGH;
            dc_next   = '0;
            low_next  = 1'b0;
            if (unstable)
            begin
                tgt_next = (tgt_dec < half_reg) ? half_reg : tgt_dec;
            end
            else if (prai_reg)
            begin
                prai_next = 1'b0;
                if (tgt_reg < full_reg) tgt_next = tgt_reg + 1'b1;
            end
        end
        else if (mean_reg > lo_th_reg && (mean_reg <= mid_up_reg || dc_reg == DERATE_MAX))
        begin
            zone_next = ZONE_MIDDLE;
            if (pder_reg)
            begin
                pder_next = 1'b0;
                low_next  = 1'b0;
                if (dc_reg < DERATE_MAX) dc_next = dc_reg + 1'b1;
                if (tgt_reg > half_reg)      tgt_next = drop2;
                else if (tgt_reg < half_reg) tgt_next = tgt_reg + 1'b1;
            end
        end
        else if (mean_reg <= lo_th_reg || low_reg)
        begin
            zone_next = ZONE_LOW;
            if (pder_reg)
            begin
                pder_next = 1'b0;
                low_next  = 1'b1;
                dc_next   = '0;
                tgt_next  = (tgt_reg > floor_reg) ? drop2 : floor_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tgt_reg   <= RST_FULL_DUTY;
            dc_reg    <= '0;
            low_reg   <= 1'b0;
            pder_reg  <= 1'b0;
            prai_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            // latch ticks on accept; consume them when the zone is applied
            if (accept)
            begin
                pder_reg <= pder_reg | in_ch.derate_tick;
                prai_reg <= prai_reg | in_ch.raise_tick;
            end
            if (finish)
            begin
                tgt_reg  <= tgt_next;
                dc_reg   <= dc_next;
                low_reg  <= low_next;
                pder_reg <= pder_next;
                prai_reg <= prai_next;
            end
            if (finish)
            begin
                out_v_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_v_reg <= 1'b0;
            end
        end
    end

    logic [DUTY_W-1:0]   o_duty_reg;
    logic [SAMPLE_W-1:0] o_level_reg;
    logic                o_unst_reg;
    logic [1:0]          o_zone_reg;

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            o_duty_reg  <= tgt_next;
            o_level_reg <= mean_reg;
            o_unst_reg  <= unstable;
            o_zone_reg  <= zone_next;
        end
    end

    assign out_ch.valid          = out_v_reg;
    assign out_ch.duty           = o_duty_reg;
    assign out_ch.smoothed_level = o_level_reg;
    assign out_ch.unstable       = o_unst_reg;
    assign out_ch.zone           = o_zone_reg;

    // checks
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_SUM))
        else $error("accepted word did not start the slot pass");

    a_extremes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && cnt_reg != '0) |-> (mn_reg <= mx_reg))
        else $error("window minimum above maximum");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_v_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside the decision step");

    a_derate_cap: assert property (@(posedge clk) disable iff (!rst_n)
        dc_reg <= DERATE_MAX)
        else $error("derate count beyond its cap");

endmodule

// ===== hdl/vdr_cell.sv =====
// ----------------------------------------------------------------------------
// vdr_cell: one storage cell of a rotating ring
// Load the fill value in parallel, or take the neighbor's value on shift.
// ----------------------------------------------------------------------------
module vdr_cell
    import vdr_pkg::*;
#(
    parameter int WIDTH = 12
)
(
    input  logic             clk,
    input  logic             fill,
    input  logic [WIDTH-1:0] fill_value,
    input  logic             shift,
    input  logic [WIDTH-1:0] shift_in,
    output logic [WIDTH-1:0] value
);

    logic [WIDTH-1:0] value_reg;

    always_ff @(posedge clk)
    begin
        if (fill)
        begin
            value_reg <= fill_value;
        end
        else if (shift)
        begin
            value_reg <= shift_in;
        end
    end

    assign value = value_reg;

endmodule

// ===== hdl/vdr_div.sv =====
// ----------------------------------------------------------------------------
// vdr_div: divider by a fixed divisor
// Multiply by the rounded-up reciprocal and shift; the quotient is registered
// and done pulses in the cycle after start.
// ----------------------------------------------------------------------------
module vdr_div
    import vdr_pkg::*;
#(
    parameter int DIVISOR    = 32,
    parameter int DIVIDEND_W = 17
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    output logic                  done,
    output logic [SAMPLE_W-1:0]   quotient
);

    // floor(n * ceil(2^(N+l) / d) / 2^(N+l)) equals floor(n / d) for n < 2^N
    localparam int SHIFT = DIVIDEND_W + ((DIVISOR > 1) ? $clog2(DIVISOR) : 0);
    localparam int MUL_W = DIVIDEND_W + 1;
    localparam longint unsigned RECIP =
        ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam logic [MUL_W-1:0] RECIP_C = MUL_W'(RECIP);

    logic [2*DIVIDEND_W:0] prod;
    logic [SAMPLE_W-1:0]   q_reg;
    logic                  done_reg;

    assign prod = {{(DIVIDEND_W+1){1'b0}}, dividend} * {{DIVIDEND_W{1'b0}}, RECIP_C};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= prod[SHIFT +: SAMPLE_W];
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule
